// ===== src/prs_pkg.sv =====
// Shared types and constants of the priority run-queue scheduler.
// No dependencies; prs_level_ctrl and priority_runqueue_scheduler import this package.
`default_nettype none

package prs_pkg;

  // Fixed field widths of the item and result beats
  localparam int unsigned PRIO_REQ_W = 5;
  localparam int unsigned LOAD_W     = 9;
  localparam int unsigned CFG_W      = 8;

  // Load counter ceiling
  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

  // Level index width at the largest supported level count (64)
  localparam int unsigned LVL_IDX_W = 6;

  // Item kind
  typedef enum logic {
    KIND_ENQUEUE  = 1'b0,
    KIND_SCHEDULE = 1'b1
  } kind_e;

  // Per-item request to the level bookkeeping
  typedef struct packed {
    logic                 push;
    logic [LVL_IDX_W-1:0] push_lvl;
    logic                 pop;
    logic [LVL_IDX_W-1:0] pop_lvl;
  } lvl_cmd_t;

endpackage

`default_nettype wire

// ===== src/prs_if.sv =====
// Valid/ready channel interfaces for item beats and result beats.
// Uses no package; widths of task identifiers come from IdW.
`default_nettype none

interface prs_item_if #(
  parameter int unsigned IdW = 8
) ();
  logic           valid;
  logic           ready;
  logic           kind;
  logic [IdW-1:0] task_id;
  logic [4:0]     priority_req;
  logic           caller_runnable;

  modport source (output valid, kind, task_id, priority_req, caller_runnable, input ready);
  modport sink   (input valid, kind, task_id, priority_req, caller_runnable, output ready);
endinterface

interface prs_result_if #(
  parameter int unsigned IdW = 8
) ();
  logic           valid;
  logic           ready;
  logic           reschedule_now;
  logic           arm_timer;
  logic [IdW-1:0] next_task;
  logic           switched;
  logic           overflow;
  logic [8:0]     load_count;

  modport source (output valid, reschedule_now, arm_timer, next_task, switched, overflow,
                  load_count, input ready);
  modport sink   (input valid, reschedule_now, arm_timer, next_task, switched, overflow,
                  load_count, output ready);
endinterface

`default_nettype wire

// ===== src/prs_fifo_mem.sv =====
// Task-id storage of all level FIFOs: one write port, one registered read port.
// Stand-alone; a read of the entry written in the same cycle returns the new data.
`default_nettype none

module prs_fifo_mem #(
  parameter int unsigned PRIO_LEVELS = 16,
  parameter int unsigned FIFO_DEPTH  = 16,
  parameter int unsigned ID_W        = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           wr_en_i,
  input  wire logic [$clog2(PRIO_LEVELS)-1:0] wr_lvl_i,
  input  wire logic [$clog2(FIFO_DEPTH)-1:0]  wr_ptr_i,
  input  wire logic [ID_W-1:0]                wr_data_i,
  input  wire logic                           rd_en_i,
  input  wire logic [$clog2(PRIO_LEVELS)-1:0] rd_lvl_i,
  input  wire logic [$clog2(FIFO_DEPTH)-1:0]  rd_ptr_i,
  output logic      [ID_W-1:0]                rd_data_o
);

  logic [ID_W-1:0] mem_q [PRIO_LEVELS][FIFO_DEPTH];
  logic [ID_W-1:0] rd_data_q;
  logic            fwd;

  assign fwd = wr_en_i && (wr_lvl_i == rd_lvl_i) && (wr_ptr_i == rd_ptr_i);

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_lvl_i][wr_ptr_i] <= wr_data_i;
    end
  end

  // registered read, forwarding a same-cycle write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= fwd ? wr_data_i : mem_q[rd_lvl_i][rd_ptr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== src/prs_level_ctrl.sv =====
// Per-level head and fill registers of the level FIFOs, with push/pop pointers.
// Depends on prs_pkg for the level command struct.
`default_nettype none

module prs_level_ctrl import prs_pkg::*; #(
  parameter int unsigned PRIO_LEVELS = 16,
  parameter int unsigned FIFO_DEPTH  = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire lvl_cmd_t                         cmd_i,
  output logic      [$clog2(FIFO_DEPTH+1)-1:0]  count_o [PRIO_LEVELS],
  output logic      [$clog2(FIFO_DEPTH)-1:0]    wr_ptr_o,
  output logic      [$clog2(FIFO_DEPTH)-1:0]    rd_ptr_o
);

  localparam int unsigned LVL_W = $clog2(PRIO_LEVELS);
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [PTR_W-1:0] head_q  [PRIO_LEVELS];
  logic [PTR_W-1:0] head_d  [PRIO_LEVELS];
  logic [CNT_W-1:0] count_q [PRIO_LEVELS];
  logic [CNT_W-1:0] count_d [PRIO_LEVELS];
  logic [LVL_W-1:0] push_lvl;
  logic [LVL_W-1:0] pop_lvl;
  logic [CNT_W:0]   tail_sum;

  assign push_lvl = LVL_W'(cmd_i.push_lvl);
  assign pop_lvl  = LVL_W'(cmd_i.pop_lvl);

  // tail slot = head + fill, wrapped once
  always_comb begin
    tail_sum = (CNT_W+1)'(head_q[push_lvl]) + (CNT_W+1)'(count_q[push_lvl]);
    if (tail_sum >= (CNT_W+1)'(FIFO_DEPTH)) begin
      tail_sum = tail_sum - (CNT_W+1)'(FIFO_DEPTH);
    end
    wr_ptr_o = PTR_W'(tail_sum);
  end

  assign rd_ptr_o = head_q[pop_lvl];

  // head advance and fill update per level
  always_comb begin
    for (int l = 0; l < PRIO_LEVELS; l++) begin
      head_d[l]  = head_q[l];
      count_d[l] = count_q[l];
      if (cmd_i.pop && (pop_lvl == LVL_W'(l))) begin
        head_d[l]  = (head_q[l] == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_q[l] + PTR_W'(1);
        count_d[l] = count_d[l] - CNT_W'(1);
      end
      if (cmd_i.push && (push_lvl == LVL_W'(l))) begin
        count_d[l] = count_d[l] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < PRIO_LEVELS; l++) begin
        head_q[l]  <= '0;
        count_q[l] <= '0;
      end
    end else begin
      for (int l = 0; l < PRIO_LEVELS; l++) begin
        head_q[l]  <= head_d[l];
        count_q[l] <= count_d[l];
      end
    end
  end

  assign count_o = count_q;

  // never push into a full level
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (count_q[push_lvl] != CNT_W'(FIFO_DEPTH)))
    else $error("push into full level");

  // a pop needs an entry, possibly the one pushed in the same beat
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> ((count_q[pop_lvl] != '0) || (cmd_i.push && (push_lvl == pop_lvl))))
    else $error("pop from empty level");

  // a lone push grows its level by one
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && !cmd_i.pop) |=>
      (count_q[$past(push_lvl)] == $past(count_q[push_lvl]) + CNT_W'(1)))
    else $error("level fill did not grow on push");

endmodule

`default_nettype wire

// ===== src/priority_runqueue_scheduler.sv =====
// Run queue of one processor: one task FIFO per priority level, enqueue and schedule beats
// in, one result beat out per item. Each item waits in the input register, where the level
// fills, the push/pop decision, the load count and the flags are settled, and then sits in
// the result register; a new item is taken every cycle unless the result beat stalls.
// The popped task id comes from the level memory's registered read port, so whether the
// schedule switched tasks is resolved in the result stage and forwarded to the next item.
// The user writes configuration (idle task id) via cfg_we_i/cfg_wdata_i only while the block is idle; not enforced.
// Depends on prs_pkg, prs_if, prs_fifo_mem and prs_level_ctrl.
`default_nettype none

module priority_runqueue_scheduler import prs_pkg::*; #(
  parameter int unsigned PRIO_LEVELS  = 16,
  parameter int unsigned FIFO_DEPTH   = 16,
  parameter int unsigned TASK_ID_BITS = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  prs_item_if.sink              in_chan,
  prs_result_if.source          out_chan
);

  localparam int unsigned LVL_W = $clog2(PRIO_LEVELS);
  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PRI_W = $clog2(PRIO_LEVELS + 1);
  localparam int unsigned ID_W  = TASK_ID_BITS;

  typedef struct packed {
    logic              resched;
    logic              arm_enq;
    logic              ovf;
    logic              is_sched;
    logic              from_mem;
    logic [ID_W-1:0]   fixed_id;
    logic [ID_W-1:0]   me;
    logic [PRI_W-1:0]  next_prio;
    logic              arm_cand;
    logic [LOAD_W-1:0] load;
  } res_t;

  // configuration and scheduler state
  logic [CFG_W-1:0]  idle_q;
  logic [ID_W-1:0]   idle_id;
  logic [ID_W-1:0]   run_task_q;
  logic [PRI_W-1:0]  run_prio_q;
  logic [LOAD_W-1:0] load_q;
  logic [LOAD_W-1:0] load_d;

  // input register
  logic                  s1_valid_q;
  kind_e                 s1_kind_q;
  logic [ID_W-1:0]       s1_id_q;
  logic [PRIO_REQ_W-1:0] s1_prio_q;
  logic                  s1_run_q;
  logic                  s1_fire;

  // result register
  logic res_valid_q;
  res_t res_q;
  res_t res_d;
  logic pend_q;

  // level bookkeeping
  lvl_cmd_t         cmd;
  lvl_cmd_t         cmd_fire;
  logic [CNT_W-1:0] count [PRIO_LEVELS];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [ID_W-1:0]  wr_data;
  logic [ID_W-1:0]  rd_data;

  // decision signals
  logic [ID_W-1:0]   eff_task;
  logic [PRI_W-1:0]  eff_prio;
  logic [PRI_W-1:0]  enq_prio;
  logic [LVL_W-1:0]  enq_lvl;
  logic [LVL_W-1:0]  re_lvl;
  logic [LVL_W-1:0]  push_lvl;
  logic [LVL_W-1:0]  pop_lvl;
  logic              push_same;
  logic [PRIO_LEVELS-1:0] nonempty;

  // result-stage resolution
  logic [ID_W-1:0] res_next_id;
  logic            res_sw;
  logic [ID_W-1:0] res_task;

  assign idle_id = ID_W'(idle_q);

  // handshake: the input register moves when the result register is free or drained
  assign s1_fire       = s1_valid_q && (!res_valid_q || out_chan.ready);
  assign in_chan.ready = !s1_valid_q || s1_fire;

  // popped id resolves the switch in the cycle after the decision
  assign res_next_id = res_q.from_mem ? rd_data : res_q.fixed_id;
  assign res_sw      = res_q.is_sched && (res_next_id != res_q.me);
  assign res_task    = res_sw ? res_next_id : res_q.me;

  // running task and priority as the item in the input register sees them
  assign eff_task = pend_q ? res_task : run_task_q;
  assign eff_prio = (pend_q && res_sw) ? res_q.next_prio : run_prio_q;

  // clamp requested priority into 1..PRIO_LEVELS
  always_comb begin
    if (s1_prio_q == '0) begin
      enq_prio = PRI_W'(1);
    end else if (32'(s1_prio_q) > PRIO_LEVELS) begin
      enq_prio = PRI_W'(PRIO_LEVELS);
    end else begin
      enq_prio = PRI_W'(s1_prio_q);
    end
    enq_lvl = LVL_W'(enq_prio - PRI_W'(1));
    re_lvl  = (eff_prio == '0) ? '0 : LVL_W'(eff_prio - PRI_W'(1));
  end

  // push/pop decision and result fields
  always_comb begin
    res_d          = '0;
    res_d.me       = eff_task;
    res_d.fixed_id = idle_id;
    load_d         = load_q;
    push_lvl       = '0;
    pop_lvl        = '0;
    wr_data        = s1_id_q;
    nonempty       = '0;
    push_same      = 1'b0;
    cmd            = '0;

    if (s1_kind_q == KIND_ENQUEUE) begin
      push_lvl = enq_lvl;
      if (count[enq_lvl] == CNT_W'(FIFO_DEPTH)) begin
        res_d.ovf = 1'b1;
      end else begin
        cmd.push      = 1'b1;
        load_d        = (load_q == LOAD_MAX) ? load_q : load_q + LOAD_W'(1);
        res_d.resched = enq_prio > eff_prio;
        res_d.arm_enq = (enq_prio == eff_prio) && (count[enq_lvl] == '0);
      end
    end else begin
      res_d.is_sched = 1'b1;
      push_lvl       = re_lvl;
      wr_data        = eff_task;
      if (eff_task != idle_id) begin
        if (s1_run_q && (count[re_lvl] != CNT_W'(FIFO_DEPTH))) begin
          cmd.push = 1'b1;
        end else begin
          res_d.ovf = s1_run_q;
          load_d    = (load_q == '0) ? load_q : load_q - LOAD_W'(1);
        end
      end

      // most urgent non-empty level, counting the task just put back
      for (int l = 0; l < PRIO_LEVELS; l++) begin
        nonempty[l] = (count[l] != '0) || (cmd.push && (re_lvl == LVL_W'(l)));
      end
      for (int l = 0; l < PRIO_LEVELS; l++) begin
        if (nonempty[l]) begin
          pop_lvl = LVL_W'(l);
        end
      end

      if (nonempty != '0) begin
        cmd.pop         = 1'b1;
        res_d.from_mem  = 1'b1;
        res_d.next_prio = PRI_W'(pop_lvl) + PRI_W'(1);
        push_same       = cmd.push && (re_lvl == pop_lvl);
        res_d.arm_cand  = (count[pop_lvl] > CNT_W'(1)) ||
                          ((count[pop_lvl] != '0) && push_same);
      end
    end

    cmd.push_lvl = LVL_IDX_W'(push_lvl);
    cmd.pop_lvl  = LVL_IDX_W'(pop_lvl);
    res_d.load   = load_d;
  end

  assign cmd_fire = s1_fire ? cmd : '0;

  prs_level_ctrl #(
    .PRIO_LEVELS (PRIO_LEVELS),
    .FIFO_DEPTH  (FIFO_DEPTH)
  ) u_level_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_fire),
    .count_o  (count),
    .wr_ptr_o (wr_ptr),
    .rd_ptr_o (rd_ptr)
  );

  prs_fifo_mem #(
    .PRIO_LEVELS (PRIO_LEVELS),
    .FIFO_DEPTH  (FIFO_DEPTH),
    .ID_W        (ID_W)
  ) u_fifo_mem (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_fire.push),
    .wr_lvl_i  (push_lvl),
    .wr_ptr_i  (wr_ptr),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_fire.pop),
    .rd_lvl_i  (pop_lvl),
    .rd_ptr_i  (rd_ptr),
    .rd_data_o (rd_data)
  );

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_kind_q <= kind_e'(in_chan.kind);
      s1_id_q   <= in_chan.task_id;
      s1_prio_q <= in_chan.priority_req;
      s1_run_q  <= in_chan.caller_runnable;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q      <= '0;
      run_task_q  <= '0;
      run_prio_q  <= PRI_W'(1);
      load_q      <= '0;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        idle_q <= cfg_wdata_i;
      end
      // commit the switch of the beat that just reached the result register
      if (pend_q) begin
        run_task_q <= res_task;
        if (res_sw) begin
          run_prio_q <= res_q.next_prio;
        end
      end
      if (s1_fire) begin
        load_q <= load_d;
      end
      pend_q <= s1_fire;
      if (in_chan.valid && in_chan.ready) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        res_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // result beat
  assign out_chan.valid          = res_valid_q;
  assign out_chan.reschedule_now = res_q.resched;
  assign out_chan.arm_timer      = res_q.is_sched ? (res_sw && res_q.arm_cand) : res_q.arm_enq;
  assign out_chan.next_task      = res_task;
  assign out_chan.switched       = res_sw;
  assign out_chan.overflow       = res_q.ovf;
  assign out_chan.load_count     = res_q.load;

  // a pending commit always belongs to the beat held in the result register
  a_pend_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> res_valid_q)
    else $error("switch commit without a result beat");

  // popped id must hold while the result beat is stalled
  a_rd_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_chan.ready && res_q.from_mem) |=> $stable(rd_data))
    else $error("popped task id changed under a stalled result");

  // an enqueue never lowers the load count
  a_enq_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_kind_q == KIND_ENQUEUE)) |=> (load_q >= $past(load_q)))
    else $error("enqueue lowered the load count");

endmodule

`default_nettype wire
